// ----- rtl/ffpa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the first-fit pool allocator.
package ffpa_pkg;

    localparam int POOL_BYTES  = 4096;
    localparam int HDR_BYTES   = 24;
    localparam int MAX_BLOCKS  = POOL_BYTES / HDR_BYTES + 2;
    localparam int LEN_W       = 13;
    localparam int OFF_W       = 12;
    localparam int AW          = 10;
    localparam int DEPTH       = POOL_BYTES / 4;
    localparam int ENT_W       = LEN_W + 1;
    localparam int CNT_W       = 8;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_REPORT  = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADREL = 2'd2;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_EVAL, S_ALLOC, S_SPLIT, S_RELNX, S_RELWR, S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic cfg_wr;
        logic init_wr;
        logic eval;
        logic advance;
        logic nofit;
        logic badrel;
        logic rel_rdnx;
        logic rel_ltnx;
        logic alloc_wr;
        logic split_wr;
        logic rel_wr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       hit;
        logic       last;
        logic       split;
        logic       out_full;
    } t_stat;

endpackage

// ----- rtl/ffpa_if.sv -----
`timescale 1ns / 1ps
// Handshake channel interfaces: configuration, request and response.
interface ffpa_cfg_if;
    import ffpa_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] pool_size;
    modport source (output valid, output pool_size, input ready);
    modport sink   (input valid, input pool_size, output ready);
endinterface

interface ffpa_req_if;
    import ffpa_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [LEN_W-1:0] request_size;
    logic [OFF_W-1:0] release_offset;
    modport source (output valid, output mode, output request_size, output release_offset,
                    input ready);
    modport sink   (input valid, input mode, input request_size, input release_offset,
                    output ready);
endinterface

interface ffpa_rsp_if;
    import ffpa_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [OFF_W-1:0] granted_offset;
    logic [LEN_W-1:0] free_total;
    logic [LEN_W-1:0] largest_free;
    modport source (output valid, output status, output granted_offset, output free_total,
                    output largest_free, input ready);
    modport sink   (input valid, input status, input granted_offset, input free_total,
                    input largest_free, output ready);
endinterface

// ----- rtl/ffpa_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ffpa_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences the block walk and the table writes.
module ffpa_ctrl import ffpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_mode,
    output logic       o_req_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;
    logic   cfg_acc, req_acc;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_req_ready = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc     = o_cfg_ready && i_cfg_valid;
    assign req_acc     = o_req_ready && i_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (cfg_acc) n_state = S_INIT;
                else if (req_acc) n_state = (i_req_mode == MODE_NONE) ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.hit) begin
                    if (i_stat.mode == MODE_ALLOC) n_state = S_ALLOC;
                    else n_state = i_stat.last ? S_RELWR : S_RELNX;
                end else if (i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_ALLOC: n_state = i_stat.split ? S_SPLIT : S_DONE;
            S_SPLIT: n_state = S_DONE;
            S_RELNX: n_state = S_RELWR;
            S_RELWR: n_state = S_DONE;
            S_DONE:  if (!i_stat.out_full) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_INIT: o_cmd.init_wr = 1'b1;
            S_IDLE: begin
                o_cmd.cfg_wr = cfg_acc;
                o_cmd.start  = req_acc;
            end
            S_EVAL: begin
                o_cmd.eval     = 1'b1;
                o_cmd.advance  = !i_stat.hit && !i_stat.last;
                o_cmd.nofit    = !i_stat.hit && i_stat.last && (i_stat.mode == MODE_ALLOC);
                o_cmd.badrel   = !i_stat.hit && i_stat.last && (i_stat.mode == MODE_RELEASE);
                o_cmd.rel_rdnx = i_stat.hit && !i_stat.last && (i_stat.mode == MODE_RELEASE);
            end
            S_ALLOC: o_cmd.alloc_wr = 1'b1;
            S_SPLIT: o_cmd.split_wr = 1'b1;
            S_RELNX: o_cmd.rel_ltnx = 1'b1;
            S_RELWR: o_cmd.rel_wr   = 1'b1;
            S_DONE:  o_cmd.finish   = !i_stat.out_full;
            default: o_cmd = '0;
        endcase
    end
endmodule

// ----- rtl/ffpa_dp.sv -----
`timescale 1ns / 1ps
// Datapath: block table RAM, walk registers, result and output registers.
module ffpa_dp import ffpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [LEN_W-1:0] i_cfg_size,
    input  logic [1:0]       i_mode,
    input  logic [LEN_W-1:0] i_req_size,
    input  logic [OFF_W-1:0] i_rel_off,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_status,
    output logic [OFF_W-1:0] o_granted,
    output logic [LEN_W-1:0] o_free_total,
    output logic [LEN_W-1:0] o_largest
);
    localparam logic [LEN_W-1:0] HDR  = LEN_W'(HDR_BYTES);
    localparam logic [LEN_W:0]   HDRW = (LEN_W+1)'(HDR_BYTES);

    logic [LEN_W-1:0] r_pool_end;
    logic [CNT_W-1:0] r_count, r_idx;
    logic [1:0]       r_mode;
    logic [LEN_W:0]   r_need;
    logic [OFF_W-1:0] r_off;
    logic [LEN_W-1:0] r_addr, r_prev_addr, r_prev_len, r_cur_len, r_rest, r_nx_len;
    logic             r_prev_busy, r_split, r_nx_free;
    logic [1:0]       r_status;
    logic [OFF_W-1:0] r_granted;
    logic [LEN_W-1:0] r_ftot, r_flarge;
    logic             r_ov;
    logic [1:0]       r_ost;
    logic [OFF_W-1:0] r_ogr;
    logic [LEN_W-1:0] r_oft, r_olg;

    logic [ENT_W-1:0] rd_data, wr_data;
    logic             rd_busy, we, re, fit, match, last, prev_free;
    logic [LEN_W-1:0] rd_len, next_addr, rd_byte, wr_byte, len_m, rest, sz;
    logic [LEN_W:0]   need_in;

    assign rd_busy   = rd_data[LEN_W];
    assign rd_len    = rd_data[LEN_W-1:0];
    assign next_addr = r_addr + HDR + rd_len;
    assign fit       = !rd_busy && ({1'b0, rd_len} > (r_need + HDRW));
    assign match     = rd_busy && ((r_addr + HDR) == {1'b0, r_off});
    assign last      = ({1'b0, r_idx} + 9'd1) == {1'b0, r_count};
    assign rest      = rd_len - r_need[LEN_W-1:0] - HDR;
    assign prev_free = (r_idx != '0) && !r_prev_busy;
    assign len_m     = r_cur_len + (r_nx_free ? (r_nx_len + HDR) : '0);
    assign need_in   = ({1'b0, i_req_size} + (LEN_W+1)'(3)) & ~(LEN_W+1)'(3);

    // Saturate the written pool size to the supported range.
    always_comb begin
        sz = i_cfg_size;
        if (i_cfg_size > LEN_W'(POOL_BYTES)) sz = LEN_W'(POOL_BYTES);
        if (i_cfg_size < HDR) sz = HDR;
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.hit      = ((r_mode == MODE_ALLOC) && fit) || ((r_mode == MODE_RELEASE) && match);
    assign o_stat.last     = last;
    assign o_stat.split    = r_split;
    assign o_stat.out_full = r_ov && !i_out_ready;

    assign re      = i_cmd.start || i_cmd.advance || i_cmd.rel_rdnx;
    assign rd_byte = i_cmd.start ? '0 : next_addr;

    always_comb begin
        we      = 1'b0;
        wr_byte = r_addr;
        wr_data = '0;
        if (i_cmd.init_wr) begin
            we      = 1'b1;
            wr_byte = '0;
            wr_data = {1'b0, r_pool_end - HDR};
        end else if (i_cmd.alloc_wr) begin
            we      = 1'b1;
            wr_data = {1'b1, r_split ? r_need[LEN_W-1:0] : r_cur_len};
        end else if (i_cmd.split_wr) begin
            we      = 1'b1;
            wr_byte = r_addr + HDR + r_need[LEN_W-1:0];
            wr_data = {1'b0, r_rest};
        end else if (i_cmd.rel_wr) begin
            we      = 1'b1;
            wr_byte = prev_free ? r_prev_addr : r_addr;
            wr_data = {1'b0, prev_free ? (r_prev_len + len_m + HDR) : len_m};
        end
    end

    ffpa_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_byte[AW+1:2]),
        .i_wdata (wr_data),
        .i_re    (re),
        .i_raddr (rd_byte[AW+1:2]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_end <= LEN_W'(POOL_BYTES);
            r_count    <= CNT_W'(1);
            r_ov       <= 1'b0;
            r_mode     <= MODE_NONE;
        end else begin
            if (i_cmd.cfg_wr) r_pool_end <= sz;
            if (i_cmd.init_wr) r_count <= CNT_W'(1);
            if (i_cmd.split_wr) r_count <= r_count + CNT_W'(1);
            if (i_cmd.rel_wr) r_count <= r_count - CNT_W'(r_nx_free) - CNT_W'(prev_free);
            if (i_cmd.start) r_mode <= i_mode;
            if (i_cmd.finish) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_need    <= need_in;
            r_off     <= i_rel_off;
            r_addr    <= '0;
            r_idx     <= '0;
            r_status  <= ST_OK;
            r_granted <= '0;
            r_ftot    <= '0;
            r_flarge  <= '0;
        end
        if (i_cmd.eval) begin
            r_cur_len <= rd_len;
            r_rest    <= rest;
            r_split   <= (last || rest > HDR) && (r_count < CNT_W'(MAX_BLOCKS));
            r_nx_free <= 1'b0;
            if (r_mode == MODE_REPORT && !rd_busy) begin
                r_ftot <= r_ftot + rd_len;
                if (rd_len > r_flarge) r_flarge <= rd_len;
            end
        end
        if (i_cmd.advance) begin
            r_prev_addr <= r_addr;
            r_prev_len  <= rd_len;
            r_prev_busy <= rd_busy;
            r_addr      <= next_addr;
            r_idx       <= r_idx + CNT_W'(1);
        end
        if (i_cmd.nofit) r_status <= ST_NOFIT;
        if (i_cmd.badrel) r_status <= ST_BADREL;
        if (i_cmd.rel_ltnx) begin
            r_nx_free <= !rd_busy;
            r_nx_len  <= rd_len;
        end
        if (i_cmd.alloc_wr) r_granted <= OFF_W'(r_addr + HDR);
        if (i_cmd.finish) begin
            r_ost <= r_status;
            r_ogr <= r_granted;
            r_oft <= r_ftot;
            r_olg <= r_flarge;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_ost;
    assign o_granted    = r_ogr;
    assign o_free_total = r_oft;
    assign o_largest    = r_olg;
endmodule

// ----- rtl/first_fit_pool_allocator_top.sv -----
`timescale 1ns / 1ps
// Throughput: one item at a time; the next item is taken only after the response is
//   loaded, so the walk (one table read a cycle, up to 172 blocks) sets the item time.
// Reset (synchronous, active low): pool size 4096, the INIT state writes the free block;
//   a pool_size write re-forms the pool the same way. Top level of the pool allocator.
module first_fit_pool_allocator_top import ffpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffpa_cfg_if.sink    i_cfg,
    ffpa_req_if.sink    i_req,
    ffpa_rsp_if.source  o_rsp
);
    t_cmd  cmd;
    t_stat stat;

    // Sequence the walk; controller sees only handshakes, req mode, datapath status.
    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold the block table and walk state; drive the response item register.
    ffpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_size   (i_cfg.pool_size),
        .i_mode       (i_req.mode),
        .i_req_size   (i_req.request_size),
        .i_rel_off    (i_req.release_offset),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_granted    (o_rsp.granted_offset),
        .o_free_total (o_rsp.free_total),
        .o_largest    (o_rsp.largest_free)
    );
endmodule

// ----- rtl/ffpa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the pool allocator, bound to the top level.
module ffpa_checker import ffpa_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [1:0]       i_status,
    input logic [OFF_W-1:0] i_granted,
    input logic [LEN_W-1:0] i_ftot,
    input logic [LEN_W-1:0] i_flarge
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_granted))
        else $error("response item changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_status <= ST_BADREL)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_granted == '0 && i_ftot == '0 && i_flarge == '0)
        else $error("failed item carries data");

    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_granted != '0 |-> i_granted >= OFF_W'(HDR_BYTES) && i_ftot == '0)
        else $error("bad granted offset");

    a_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_flarge <= i_ftot)
        else $error("largest free block exceeds free total");
endmodule

bind first_fit_pool_allocator_top ffpa_checker u_ffpa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_status  (o_rsp.status),
    .i_granted (o_rsp.granted_offset),
    .i_ftot    (o_rsp.free_total),
    .i_flarge  (o_rsp.largest_free)
);

// ----- tb/tb_first_fit_pool_allocator_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_pool_allocator_top: random allocate/release/report traffic.
module tb_first_fit_pool_allocator_top;
    import ffpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int NUM_PHASES     = 10;

    typedef struct {
        logic [1:0]       mode;
        logic [LEN_W-1:0] request_size;
        logic [OFF_W-1:0] release_offset;
    } t_request;

    typedef struct {
        logic [1:0]       status;
        logic [OFF_W-1:0] granted_offset;
        logic [LEN_W-1:0] free_total;
        logic [LEN_W-1:0] largest_free;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    ffpa_cfg_if cfg ();
    ffpa_req_if req ();
    ffpa_rsp_if rsp ();

    first_fit_pool_allocator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Shadow copy of the block list: start, payload length and busy flag per block.
    int unsigned blk_base [MAX_BLOCKS];
    int unsigned blk_size [MAX_BLOCKS];
    bit          blk_taken[MAX_BLOCKS];
    int unsigned blk_total;

    t_request queued_requests[$];
    t_reply   awaited_replies[$];

    int  mismatches;
    int  stall_free;      // set for the last phase: no idling on either side
    int  squeeze_asked;
    int  squeeze_done;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Rebuild the pool as one free block; clamp the size into the legal range.
    function automatic void rebuild_pool(input int unsigned size_bytes);
        int unsigned sz;
        sz = size_bytes;
        if (sz > POOL_BYTES) sz = POOL_BYTES;
        if (sz < HDR_BYTES) sz = HDR_BYTES;
        blk_base[0]  = 0;
        blk_size[0]  = sz - HDR_BYTES;
        blk_taken[0] = 1'b0;
        blk_total    = 1;
    endfunction

    // Drop block k from the list, closing the gap.
    function automatic void drop_block(input int unsigned k);
        for (int unsigned j = k; j + 1 < blk_total; j++) begin
            blk_base[j]  = blk_base[j + 1];
            blk_size[j]  = blk_size[j + 1];
            blk_taken[j] = blk_taken[j + 1];
        end
        blk_total--;
    endfunction

    // Apply one request to the shadow pool and return the reply it must produce.
    function automatic t_reply apply_request(input t_request r);
        t_reply      rep;
        int unsigned need;
        int unsigned rest;
        int unsigned tot;
        int unsigned big;
        int unsigned granted;
        bit          last;
        rep     = '{default: '0};
        tot     = 0;
        big     = 0;
        granted = 0;
        case (r.mode)
            MODE_ALLOC: begin
                need = ((int'(r.request_size) + 3) / 4) * 4;
                rep.status = ST_NOFIT;
                for (int unsigned i = 0; i < blk_total; i++) begin
                    if (!blk_taken[i] && blk_size[i] > need + HDR_BYTES) begin
                        rest = blk_size[i] - need - HDR_BYTES;
                        last = (i + 1 == blk_total);
                        blk_taken[i] = 1'b1;
                        // Split off a tail if last or rest > HDR_BYTES and the table is not full.
                        if ((last || rest > HDR_BYTES) && blk_total < MAX_BLOCKS) begin
                            for (int unsigned j = blk_total; j > i + 1; j--) begin
                                blk_base[j]  = blk_base[j - 1];
                                blk_size[j]  = blk_size[j - 1];
                                blk_taken[j] = blk_taken[j - 1];
                            end
                            blk_size[i]      = need;
                            blk_base[i + 1]  = blk_base[i] + HDR_BYTES + need;
                            blk_size[i + 1]  = rest;
                            blk_taken[i + 1] = 1'b0;
                            blk_total++;
                        end
                        granted    = blk_base[i] + HDR_BYTES;
                        rep.status = ST_OK;
                        break;
                    end
                end
            end
            MODE_RELEASE: begin
                rep.status = ST_BADREL;
                for (int unsigned i = 0; i < blk_total; i++) begin
                    if (blk_base[i] + HDR_BYTES == r.release_offset && blk_taken[i]) begin
                        blk_taken[i] = 1'b0;
                        // Merge with a free successor, then with a free predecessor.
                        if (i + 1 < blk_total && !blk_taken[i + 1]) begin
                            blk_size[i] += blk_size[i + 1] + HDR_BYTES;
                            drop_block(i + 1);
                        end
                        if (i > 0 && !blk_taken[i - 1]) begin
                            blk_size[i - 1] += blk_size[i] + HDR_BYTES;
                            drop_block(i);
                        end
                        rep.status = ST_OK;
                        break;
                    end
                end
            end
            MODE_REPORT: begin
                for (int unsigned i = 0; i < blk_total; i++) begin
                    if (!blk_taken[i]) begin
                        tot += blk_size[i];
                        if (blk_size[i] > big) big = blk_size[i];
                    end
                end
            end
            default: ;
        endcase
        rep.granted_offset = granted[OFF_W-1:0];
        rep.free_total     = tot[LEN_W-1:0];
        rep.largest_free   = big[LEN_W-1:0];
        return rep;
    endfunction

    // Pick the payload offset of some busy block, or a random offset if none is busy.
    function automatic logic [OFF_W-1:0] busy_offset();
        int unsigned picks[$];
        for (int unsigned i = 0; i < blk_total; i++)
            if (blk_taken[i]) picks.push_back(blk_base[i] + HDR_BYTES);
        if (picks.size() == 0) return OFF_W'($urandom);
        return OFF_W'(picks[$urandom_range(0, picks.size() - 1)]);
    endfunction

    function automatic t_request make_request(input logic [1:0] m, input int unsigned sz,
                                              input int unsigned off);
        t_request r;
        r.mode           = m;
        r.request_size   = LEN_W'(sz);
        r.release_offset = OFF_W'(off);
        return r;
    endfunction

    // Random item, biased toward well-formed allocate/release traffic.
    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        int unsigned sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        r = make_request(MODE_ALLOC, $urandom, $urandom);
        if (pick < 40) begin
            if (sel < 80)      r.request_size = LEN_W'($urandom_range(0, 160));
            else if (sel < 95) r.request_size = LEN_W'($urandom_range(0, 4096));
        end else if (pick < 75) begin
            r.mode           = MODE_RELEASE;
            r.release_offset = busy_offset();
        end else if (pick < 85) begin
            r.mode = MODE_REPORT;
        end else if (pick < 93) begin
            r.mode = MODE_RELEASE;
        end else begin
            r.mode = MODE_NONE;
        end
        return r;
    endfunction

    // Driver: offer queued items, hold an item until it is taken, idle in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            send_gap  <= 0;
        end else begin
            if (req.valid && req.ready)
                awaited_replies.push_back(apply_request(make_request(req.mode,
                    req.request_size, req.release_offset)));
            if (req.valid && !req.ready) begin
                // hold the current item
            end else if (send_gap > 0) begin
                send_gap  <= send_gap - 1;
                req.valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
                t_request nxt;
                nxt = queued_requests.pop_front();
                req.valid          <= 1'b1;
                req.mode           <= nxt.mode;
                req.request_size   <= nxt.request_size;
                req.release_offset <= nxt.release_offset;
                if (!stall_free && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 14);
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each reply against the oldest expectation and drive ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready    <= 1'b0;
            recv_gap     <= 0;
            hold_left    <= 0;
            squeeze_done <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply with nothing expected: status %0d offset %0d",
                                 rsp.status, rsp.granted_offset);
                end else begin
                    t_reply exp;
                    exp = awaited_replies.pop_front();
                    if (rsp.status !== exp.status || rsp.granted_offset !== exp.granted_offset
                        || rsp.free_total !== exp.free_total
                        || rsp.largest_free !== exp.largest_free) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected st %0d off %0d free %0d big %0d, got st %0d off %0d free %0d big %0d",
                                     exp.status, exp.granted_offset, exp.free_total,
                                     exp.largest_free, rsp.status, rsp.granted_offset,
                                     rsp.free_total, rsp.largest_free);
                    end
                end
            end
            // A requested squeeze holds ready low long enough to back up the input.
            if (squeeze_asked != squeeze_done) begin
                squeeze_done <= squeeze_asked;
                hold_left    <= SQUEEZE_CYCLES;
                rsp.ready    <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap  <= recv_gap - 1;
                rsp.ready <= 1'b0;
            end else if (!stall_free && $urandom_range(0, 7) == 0) begin
                recv_gap  <= $urandom_range(1, 14) - 1;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_pool_allocator_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every queued item is taken and every reply has come back.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (queued_requests.size() != 0 || awaited_replies.size() != 0 || req.valid);
        repeat (10) @(posedge i_clk);
    endtask

    // Write the pool size while the block is idle; the shadow pool follows on acceptance.
    task automatic write_pool_size(input logic [LEN_W-1:0] value);
        cfg.valid     <= 1'b1;
        cfg.pool_size <= value;
        do @(posedge i_clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        rebuild_pool(value);
    endtask

    initial begin
        int unsigned pool_plan[NUM_PHASES];
        int unsigned item_plan[NUM_PHASES];
        int unsigned left;
        int unsigned batch;
        pool_plan = '{4096, 64, 8191, 0, 23, 24, 300, 4096, 1024, 4096};
        item_plan = '{160, 80, 140, 25, 25, 25, 110, 180, 120, 190};
        pool_plan[8] = $urandom_range(64, 4096);
        mismatches    = 0;
        stall_free    = 0;
        squeeze_asked = 0;
        quiet_cycles  = 0;
        cfg.valid     = 1'b0;
        cfg.pool_size = '0;
        req.valid          = 1'b0;
        req.mode           = MODE_ALLOC;
        req.request_size   = '0;
        req.release_offset = '0;
        rsp.ready = 1'b0;
        i_rst_n   = 1'b0;
        rebuild_pool(4096);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: field extremes, every mode, split and merge corners, bad release.
        queued_requests.push_back(make_request(MODE_REPORT, 0, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 8191, 4095));
        queued_requests.push_back(make_request(MODE_ALLOC, 4096, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 4045, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 4044, 0));
        queued_requests.push_back(make_request(MODE_REPORT, 8191, 4095));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 24));
        queued_requests.push_back(make_request(MODE_RELEASE, 8191, 24));
        queued_requests.push_back(make_request(MODE_ALLOC, 0, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 1, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 3, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 47, 0));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 28));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 0));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 4095));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 52));
        queued_requests.push_back(make_request(MODE_REPORT, 0, 0));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 24));
        queued_requests.push_back(make_request(MODE_RELEASE, 0, 80));
        queued_requests.push_back(make_request(MODE_REPORT, 0, 0));
        queued_requests.push_back(make_request(MODE_NONE, 8191, 4095));
        queued_requests.push_back(make_request(MODE_NONE, 0, 0));
        queued_requests.push_back(make_request(MODE_ALLOC, 4047, 2730));
        queued_requests.push_back(make_request(MODE_REPORT, 5461, 1365));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                write_pool_size(LEN_W'(pool_plan[p]));
            end
            if (p == NUM_PHASES - 1) stall_free = 1;
            left = item_plan[p];
            while (left > 0) begin
                batch = $urandom_range(1, 6);
                if (batch > left) batch = left;
                for (int unsigned k = 0; k < batch; k++)
                    queued_requests.push_back(random_request());
                left -= batch;
                // Once, back the block up: hold the receiver while items pile in.
                if (p == 1 && left < item_plan[p] / 2 && squeeze_asked == 0) begin
                    for (int k = 0; k < 12; k++)
                        queued_requests.push_back(random_request());
                    squeeze_asked = 1;
                end
                // Let the shadow pool catch up so releases name live blocks.
                do @(posedge i_clk);
                while (queued_requests.size() != 0);
            end
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("first_fit_pool_allocator_top verification clean");
        end else begin
            $display("first_fit_pool_allocator_top verification failed");
        end
        $finish;
    end

endmodule
